### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked implication checks, disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/colagg_pkg.sv
// ----------------------------------------------------------------------------
// colagg_pkg
// shared constants and types of the column aggregate block
// ----------------------------------------------------------------------------
`default_nettype none

package colagg_pkg;

    localparam int DATA_W    = 64;
    localparam int MODE_W    = 3;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 6;

    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUM   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AVG   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAX   = 3'd4;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sum;
        logic signed [DATA_W-1:0] min;
        logic signed [DATA_W-1:0] max;
        logic                     saturated;
    } t_acc_totals;

endpackage

`default_nettype wire

### hdl/colagg_in_if.sv
// ----------------------------------------------------------------------------
// colagg_in_if
// row channel: one column value per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface colagg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [colagg_pkg::DATA_W-1:0]  row_data;
    logic                                  last_row;

    modport source (output valid, output row_data, output last_row, input ready);
    modport sink   (input valid, input row_data, input last_row, output ready);
endinterface

`default_nettype wire

### hdl/colagg_out_if.sv
// ----------------------------------------------------------------------------
// colagg_out_if
// result channel: one aggregate per column
// ----------------------------------------------------------------------------
`default_nettype none

interface colagg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [colagg_pkg::DATA_W-1:0]  aggregate_value;
    logic                                  column_empty;
    logic                                  sum_overflow;

    modport source (output valid, output aggregate_value, output column_empty,
                    output sum_overflow, input ready);
    modport sink   (input valid, input aggregate_value, input column_empty,
                    input sum_overflow, output ready);
endinterface

`default_nettype wire

### hdl/colagg_accum.sv
// ----------------------------------------------------------------------------
// colagg_accum
// running tally, saturating sum, minimum and maximum of one column
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module colagg_accum #(
    parameter int ROW_COUNT_BITS = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_clear,
    input  wire logic signed [colagg_pkg::DATA_W-1:0] i_value,
    output logic [ROW_COUNT_BITS-1:0]                 o_tally,
    output colagg_pkg::t_acc_totals                   o_totals
);

    logic [ROW_COUNT_BITS-1:0]          r_tally;
    logic signed [colagg_pkg::DATA_W-1:0] r_sum;
    logic signed [colagg_pkg::DATA_W-1:0] r_min;
    logic signed [colagg_pkg::DATA_W-1:0] r_max;
    logic                               r_sat;

    logic signed [colagg_pkg::DATA_W-1:0] n_sum;
    logic                               w_ovf;

    always_comb begin
        n_sum = r_sum + i_value;
        w_ovf = (r_sum[colagg_pkg::DATA_W-1] == i_value[colagg_pkg::DATA_W-1]) &&
                (n_sum[colagg_pkg::DATA_W-1] != r_sum[colagg_pkg::DATA_W-1]);
        if (w_ovf) begin
            n_sum = r_sum[colagg_pkg::DATA_W-1] ? colagg_pkg::VAL_MIN : colagg_pkg::VAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tally <= '0;
            r_sum   <= '0;
            r_min   <= colagg_pkg::VAL_MAX;
            r_max   <= colagg_pkg::VAL_MIN;
            r_sat   <= 1'b0;
        end else if (i_en) begin
            r_sum <= n_sum;
            if (w_ovf) begin
                r_sat <= 1'b1;
            end
            if (r_tally != '1) begin
                r_tally <= r_tally + 1'b1;
            end
            if (i_value < r_min) begin
                r_min <= i_value;
            end
            if (i_value > r_max) begin
                r_max <= i_value;
            end
        end
    end

    assign o_tally            = r_tally;
    assign o_totals.sum       = r_sum;
    assign o_totals.min       = r_min;
    assign o_totals.max       = r_max;
    assign o_totals.saturated = r_sat;

    `ASSERT_IMPL(a_sat_clears_on_end, $fell(r_sat), $past(i_clear), "overflow flag dropped mid column")
    `ASSERT_NEXT(a_clear_zeroes_tally, i_clear, r_tally == '0, "tally not cleared")

endmodule

`default_nettype wire

### hdl/colagg_div.sv
// ----------------------------------------------------------------------------
// colagg_div
// restoring divider, one quotient bit per cycle through one subtractor
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module colagg_div #(
    parameter int DIVISOR_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [colagg_pkg::DATA_W-1:0]  i_dividend,
    input  wire logic [DIVISOR_BITS-1:0]        i_divisor,
    output logic                                o_done,
    output logic [colagg_pkg::DATA_W-1:0]       o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [colagg_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [colagg_pkg::DATA_W-1:0]       r_quo;
    logic [DIVISOR_BITS-1:0]             r_rem;
    logic [DIVISOR_BITS-1:0]             r_dvs;

    logic [DIVISOR_BITS:0]               w_shift;
    logic [DIVISOR_BITS+1:0]             w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[colagg_pkg::DATA_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= colagg_pkg::DIV_CNT_W'(colagg_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DIVISOR_BITS+1]) begin
                r_rem <= w_diff[DIVISOR_BITS-1:0];
            end else begin
                r_rem <= w_shift[DIVISOR_BITS-1:0];
            end
            r_quo <= {r_quo[colagg_pkg::DATA_W-2:0], ~w_diff[DIVISOR_BITS+1]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_IMPL(a_done_after_busy, r_done, $past(r_busy), "divider done without a run")

endmodule

`default_nettype wire

### hdl/column_aggregate.sv
// ----------------------------------------------------------------------------
// column_aggregate
// streaming count, sum, average, minimum and maximum of one integer column
// ----------------------------------------------------------------------------
// usage
//   i_row carries one row value per transaction; last_row closes the column.
//   o_result carries one transaction per column with the aggregate picked by
//   the mode register (i_cfg_we / i_cfg_wdata), plus empty and overflow flags.
//   rows that are not last are taken one per cycle with no output.
//   after a last row the row channel is held off while the result is built:
//   count, sum, min and max go from S_FIN straight to S_EMIT; the average of
//   a non-empty column first runs the 64 steps of the one-bit-per-cycle divider.
//   the result sits in an output register; if the receiver stalls, the block
//   waits with the finished result and takes no new rows until it is loaded.
//   reset (synchronous, active low) clears the running totals, sets the
//   mode to count and drops any pending result.
//   the mode register must be written only while no column is being closed; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module column_aggregate #(
    parameter int ROW_COUNT_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [colagg_pkg::MODE_W-1:0]       i_cfg_wdata,
    colagg_in_if.sink                                i_row,
    colagg_out_if.source                             o_result
);

    localparam logic [1:0] S_ROW  = 2'd0;
    localparam logic [1:0] S_FIN  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                           r_state;
    logic [1:0]                           n_state;
    logic [colagg_pkg::MODE_W-1:0]        r_mode;
    logic                                 r_neg;
    logic signed [colagg_pkg::DATA_W-1:0] r_avg;

    logic                                 r_out_valid;
    logic signed [colagg_pkg::DATA_W-1:0] r_out_value;
    logic                                 r_out_empty;
    logic                                 r_out_ovf;

    logic [ROW_COUNT_BITS-1:0]            w_tally;
    colagg_pkg::t_acc_totals              w_totals;
    logic                                 w_row_take;
    logic                                 w_emit;
    logic                                 w_div_start;
    logic                                 w_div_done;
    logic [colagg_pkg::DATA_W-1:0]        w_quot;
    logic [colagg_pkg::DATA_W-1:0]        w_mag;
    logic signed [colagg_pkg::DATA_W-1:0] w_sel;

    assign i_row.ready = (r_state == S_ROW);
    assign w_row_take  = i_row.valid && i_row.ready;
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || o_result.ready);
    assign w_div_start = (r_state == S_FIN) && (r_mode == colagg_pkg::MODE_AVG) &&
                         (w_tally != '0);
    assign w_mag       = w_totals.sum[colagg_pkg::DATA_W-1] ?
                         (colagg_pkg::DATA_W'(0) - w_totals.sum) : w_totals.sum;

    colagg_accum #(
        .ROW_COUNT_BITS (ROW_COUNT_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_row_take),
        .i_clear  (w_emit),
        .i_value  (i_row.row_data),
        .o_tally  (w_tally),
        .o_totals (w_totals)
    );

    colagg_div #(
        .DIVISOR_BITS (ROW_COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_tally),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ROW: begin
                if (w_row_take && i_row.last_row) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = w_div_start ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_ROW;
                end
            end
            default: n_state = S_ROW;
        endcase
    end

    always_comb begin
        unique case (r_mode)
            colagg_pkg::MODE_COUNT: w_sel = {{(colagg_pkg::DATA_W-ROW_COUNT_BITS){1'b0}}, w_tally};
            colagg_pkg::MODE_SUM:   w_sel = w_totals.sum;
            colagg_pkg::MODE_AVG:   w_sel = r_avg;
            colagg_pkg::MODE_MIN:   w_sel = w_totals.min;
            colagg_pkg::MODE_MAX:   w_sel = w_totals.max;
            default:                w_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ROW;
            r_mode      <= colagg_pkg::MODE_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_neg <= w_totals.sum[colagg_pkg::DATA_W-1];
            r_avg <= '0;
        end
        if (w_div_done) begin
            r_avg <= r_neg ? (colagg_pkg::DATA_W'(0) - w_quot) : w_quot;
        end
        if (w_emit) begin
            r_out_value <= w_sel;
            r_out_empty <= (w_tally == '0);
            r_out_ovf   <= w_totals.saturated;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.aggregate_value = r_out_value;
    assign o_result.column_empty    = r_out_empty;
    assign o_result.sum_overflow    = r_out_ovf;

    `ASSERT_IMPL(a_result_from_emit, $rose(r_out_valid), $past(r_state) == S_EMIT, "stray result")
    `ASSERT_IMPL(a_div_only_avg, r_state == S_DIV, r_mode == colagg_pkg::MODE_AVG, "divide not avg")

endmodule

`default_nettype wire
